### src/hsv2rgb_pkg.sv
// Shared constants and types for the HSV to RGB pixel converter.
package hsv2rgb_pkg;

  localparam int HueWidth   = 9;
  localparam int LevelWidth = 8;
  localparam int RemWidth   = 6;
  localparam int SecWidth   = 3;
  localparam int SpanWidth  = 14;
  localparam int InBytes    = 4;
  localparam int OutBytes   = 3;
  localparam int NumStages  = 7;

  localparam logic [HueWidth-1:0]   HueFull    = 9'd360;
  localparam logic [RemWidth-1:0]   SectorSpan = 6'd60;
  localparam logic [LevelWidth-1:0] LevelMax   = 8'd255;
  localparam logic [SpanWidth-1:0]  SpanScale  = 14'd15300;

  // Division by 3825 (15300 / 4) is exact for 20-bit numerators with this
  // reciprocal and a shift of 32. Division by 255 is exact for 16-bit
  // numerators with 32897 and a shift of 23.
  localparam logic [20:0] RecipSpan  = 21'd1122868;
  localparam logic [15:0] RecipLevel = 16'd32897;

  localparam logic [SecWidth-1:0] SectorRedYellow   = 3'd0;
  localparam logic [SecWidth-1:0] SectorYellowGreen = 3'd1;
  localparam logic [SecWidth-1:0] SectorGreenCyan   = 3'd2;
  localparam logic [SecWidth-1:0] SectorCyanBlue    = 3'd3;
  localparam logic [SecWidth-1:0] SectorBlueMagenta = 3'd4;
  localparam logic [SecWidth-1:0] SectorMagentaRed  = 3'd5;

  typedef struct packed {
    logic [SecWidth-1:0] sector;
    logic [RemWidth-1:0] rem;
  } hue_pos_t;

  typedef struct packed {
    logic [LevelWidth-1:0] p;
    logic [LevelWidth-1:0] q;
    logic [LevelWidth-1:0] t;
  } levels_t;

endpackage

### src/hsv2rgb_sector.sv
// Hue reduction modulo 360 and split into sector and offset, two stages.
module hsv2rgb_sector (
  input  logic                                clk,
  input  logic [1:0]                          en,
  input  logic [hsv2rgb_pkg::HueWidth-1:0]    hue,
  input  logic [hsv2rgb_pkg::LevelWidth-1:0]  saturation,
  input  logic [hsv2rgb_pkg::LevelWidth-1:0]  brightness,
  output hsv2rgb_pkg::hue_pos_t               pos,
  output logic [hsv2rgb_pkg::LevelWidth-1:0]  sat_out,
  output logic [hsv2rgb_pkg::LevelWidth-1:0]  val_out
);
  import hsv2rgb_pkg::*;

  logic [HueWidth-1:0]   hue_mod;
  logic [LevelWidth-1:0] sat_a;
  logic [LevelWidth-1:0] val_a;
  logic [SecWidth-1:0]   sector_next;
  logic [HueWidth-1:0]   base_next;
  logic [HueWidth-1:0]   rem_full;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hue_mod <= (hue >= HueFull) ? hue - HueFull : hue;
      sat_a   <= saturation;
      val_a   <= brightness;
    end
  end

  always_comb begin
    if (hue_mod >= 9'd300) begin
      sector_next = SectorMagentaRed;
      base_next   = 9'd300;
    end else if (hue_mod >= 9'd240) begin
      sector_next = SectorBlueMagenta;
      base_next   = 9'd240;
    end else if (hue_mod >= 9'd180) begin
      sector_next = SectorCyanBlue;
      base_next   = 9'd180;
    end else if (hue_mod >= 9'd120) begin
      sector_next = SectorGreenCyan;
      base_next   = 9'd120;
    end else if (hue_mod >= 9'(SectorSpan)) begin
      sector_next = SectorYellowGreen;
      base_next   = 9'(SectorSpan);
    end else begin
      sector_next = SectorRedYellow;
      base_next   = '0;
    end
    rem_full = hue_mod - base_next;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pos.sector <= sector_next;
      pos.rem    <= rem_full[RemWidth-1:0];
      sat_out    <= sat_a;
      val_out    <= val_a;
    end
  end

endmodule

### src/hsv2rgb_levels.sv
// Derived levels p, q and t through four multiply and divide stages.
module hsv2rgb_levels (
  input  logic                                clk,
  input  logic [3:0]                          en,
  input  hsv2rgb_pkg::hue_pos_t               pos,
  input  logic [hsv2rgb_pkg::LevelWidth-1:0]  sat_in,
  input  logic [hsv2rgb_pkg::LevelWidth-1:0]  val_in,
  output hsv2rgb_pkg::levels_t                lev,
  output logic [hsv2rgb_pkg::SecWidth-1:0]    sector_out,
  output logic [hsv2rgb_pkg::LevelWidth-1:0]  val_out
);
  import hsv2rgb_pkg::*;

  logic [SpanWidth-1:0]  s_rem;
  logic [SpanWidth-1:0]  s_comp;
  logic [LevelWidth-1:0] sat_inv;
  logic [SecWidth-1:0]   sec_c;
  logic [LevelWidth-1:0] val_c;

  logic [21:0]           prod_q;
  logic [21:0]           prod_t;
  logic [15:0]           prod_p;
  logic [SecWidth-1:0]   sec_d;
  logic [LevelWidth-1:0] val_d;

  logic [30:0]           q_hi;
  logic [30:0]           q_lo;
  logic [30:0]           t_hi;
  logic [30:0]           t_lo;
  logic [31:0]           p_scaled;
  logic [SecWidth-1:0]   sec_e;
  logic [LevelWidth-1:0] val_e;

  logic [40:0]           q_sum;
  logic [40:0]           t_sum;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s_rem   <= SpanWidth'(sat_in * pos.rem);
      s_comp  <= SpanWidth'(sat_in * RemWidth'(SectorSpan - pos.rem));
      sat_inv <= LevelMax - sat_in;
      sec_c   <= pos.sector;
      val_c   <= val_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod_q <= 22'(val_c * SpanWidth'(SpanScale - s_rem));
      prod_t <= 22'(val_c * SpanWidth'(SpanScale - s_comp));
      prod_p <= 16'(val_c * sat_inv);
      sec_d  <= sec_c;
      val_d  <= val_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      q_hi     <= 31'(prod_q[21:12] * RecipSpan);
      q_lo     <= 31'(prod_q[11:2] * RecipSpan);
      t_hi     <= 31'(prod_t[21:12] * RecipSpan);
      t_lo     <= 31'(prod_t[11:2] * RecipSpan);
      p_scaled <= 32'(prod_p * RecipLevel);
      sec_e    <= sec_d;
      val_e    <= val_d;
    end
  end

  assign q_sum = {q_hi, 10'b0} + 41'(q_lo);
  assign t_sum = {t_hi, 10'b0} + 41'(t_lo);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      lev.q      <= q_sum[39:32];
      lev.t      <= t_sum[39:32];
      lev.p      <= p_scaled[30:23];
      sector_out <= sec_e;
      val_out    <= val_e;
    end
  end

endmodule

### src/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB pixel converter with stage control and output register.
//
//  channel | direction | tdata bits (low to high)               | tlast/tuser
//  s_axis  | in        | hue[8:0] saturation[16:9] brightness[24:17] | none
//  m_axis  | out       | red[7:0] green[15:8] blue[23:16]        | none
//
// One item per clock is taken and given while m_tready is high; each item passes
// the hue split, level multiplies, split reciprocal divide and output register.
// Reset clears every stage valid bit; payload registers are not reset.
// Each stage holds its item while the stage after it is full and stalled, and
// empty stages keep filling, so a stall loses and repeats nothing.
module hsv_to_rgb_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // hue, saturation, brightness, zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // red, green, blue
);
  import hsv2rgb_pkg::*;

  logic [NumStages-1:0]  vld;
  logic [NumStages:0]    rdy;
  hue_pos_t              pos;
  logic [LevelWidth-1:0] sat_b;
  logic [LevelWidth-1:0] val_b;
  levels_t               lev;
  logic [SecWidth-1:0]   sec_f;
  logic [LevelWidth-1:0] val_f;
  logic [LevelWidth-1:0] red;
  logic [LevelWidth-1:0] green;
  logic [LevelWidth-1:0] blue;
  logic [LevelWidth-1:0] red_next;
  logic [LevelWidth-1:0] green_next;
  logic [LevelWidth-1:0] blue_next;

  always_comb begin
    rdy[NumStages] = m_tready;
    for (int k = NumStages - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) begin
          vld[k] <= (k == 0) ? s_tvalid : vld[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  hsv2rgb_sector u_sector (
    .clk        (clk),
    .en         (rdy[1:0]),
    .hue        (s_tdata[8:0]),
    .saturation (s_tdata[16:9]),
    .brightness (s_tdata[24:17]),
    .pos        (pos),
    .sat_out    (sat_b),
    .val_out    (val_b)
  );

  hsv2rgb_levels u_levels (
    .clk        (clk),
    .en         (rdy[5:2]),
    .pos        (pos),
    .sat_in     (sat_b),
    .val_in     (val_b),
    .lev        (lev),
    .sector_out (sec_f),
    .val_out    (val_f)
  );

  always_comb begin
    case (sec_f)
      SectorRedYellow: begin
        red_next = val_f; green_next = lev.t; blue_next = lev.p;
      end
      SectorYellowGreen: begin
        red_next = lev.q; green_next = val_f; blue_next = lev.p;
      end
      SectorGreenCyan: begin
        red_next = lev.p; green_next = val_f; blue_next = lev.t;
      end
      SectorCyanBlue: begin
        red_next = lev.p; green_next = lev.q; blue_next = val_f;
      end
      SectorBlueMagenta: begin
        red_next = lev.t; green_next = lev.p; blue_next = val_f;
      end
      default: begin
        red_next = val_f; green_next = lev.p; blue_next = lev.q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[NumStages-1]) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[NumStages-1];
  assign m_tdata  = {blue, green, red};

endmodule

### src/hsv2rgb_checker.sv
// Port-level assertions for the HSV to RGB converter and their bind.
module hsv2rgb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Output valid after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled output item changed or dropped.");

  a_flow: assert property (@(posedge clk) m_tready |-> s_tready)
    else $error("Input stalled while output side is ready.");

  a_grey: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata[16:9] == 8'd0 && m_tready
    ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
    ##1 m_tready |=> m_tvalid && m_tdata[7:0] == $past(s_tdata[24:17], 7)
      && m_tdata[15:8] == m_tdata[7:0] && m_tdata[23:16] == m_tdata[7:0])
    else $error("Zero saturation item did not come out grey.");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (.*);
